FILE: src/rcfp_pkg.sv
package rcfp_pkg;

	// Frame layout
	localparam int unsigned FRAME_LENGTH = 17;
	localparam int unsigned GROUP_LEN    = 5;
	localparam int unsigned IDX_W        = 5;

	localparam logic [IDX_W-1:0] KP_FIRST   = IDX_W'(1);
	localparam logic [IDX_W-1:0] KP_LAST    = IDX_W'(GROUP_LEN);
	localparam logic [IDX_W-1:0] KI_FIRST   = IDX_W'(GROUP_LEN + 1);
	localparam logic [IDX_W-1:0] KI_LAST    = IDX_W'(2 * GROUP_LEN);
	localparam logic [IDX_W-1:0] KD_FIRST   = IDX_W'(2 * GROUP_LEN + 1);
	localparam logic [IDX_W-1:0] KD_LAST    = IDX_W'(3 * GROUP_LEN);
	localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(FRAME_LENGTH - 1);

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned VEL_W   = 16;
	localparam int unsigned TURN_W  = 8;
	localparam int unsigned GAIN_W  = 23;
	localparam int unsigned SPEED_W = 7;
	localparam int unsigned RATE_W  = 7;
	localparam int unsigned STEP_W  = 5;

	// Received byte codes
	localparam logic [BYTE_W-1:0] CH_TOGGLE  = 8'h39; // '9'
	localparam logic [BYTE_W-1:0] CH_HEADER  = 8'h41; // 'A'
	localparam logic [BYTE_W-1:0] CH_TRAILER = 8'h42; // 'B'
	localparam logic [BYTE_W-1:0] CH_REV     = 8'h31; // '1'
	localparam logic [BYTE_W-1:0] CH_LEFT    = 8'h32; // '2'
	localparam logic [BYTE_W-1:0] CH_STOP    = 8'h33; // '3'
	localparam logic [BYTE_W-1:0] CH_RIGHT   = 8'h34; // '4'
	localparam logic [BYTE_W-1:0] CH_FWD     = 8'h35; // '5'
	localparam logic [BYTE_W-1:0] CH_FASTER  = 8'h36; // '6'
	localparam logic [BYTE_W-1:0] CH_SLOWER  = 8'h37; // '7'
	localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd48;

	// Command queue
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REG_DRIVE_SPEED = 2'd0,
		REG_TURN_RATE   = 2'd1,
		REG_SPEED_STEP  = 2'd2
	} reg_idx_t;

	localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST = 7'd30;
	localparam logic [RATE_W-1:0]  TURN_RATE_RST   = 7'd40;
	localparam logic [STEP_W-1:0]  SPEED_STEP_RST  = 5'd5;

	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_REV    = 3'd1,
		OP_LEFT   = 3'd2,
		OP_STOP   = 3'd3,
		OP_RIGHT  = 3'd4,
		OP_FWD    = 3'd5,
		OP_FASTER = 3'd6,
		OP_SLOWER = 3'd7
	} drive_op_t;

	// One classified item as it waits between front and back
	typedef struct packed {
		logic              tuning;
		drive_op_t         op;
		logic [BYTE_W-1:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		logic [SPEED_W-1:0] drive_speed;
		logic [RATE_W-1:0]  turn_rate;
		logic [STEP_W-1:0]  speed_step;
	} cfg_t;

endpackage

FILE: src/rcfp_rx_if.sv
interface rcfp_rx_if
	import rcfp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/rcfp_res_if.sv
interface rcfp_res_if
	import rcfp_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     tuning_mode;
	logic signed [VEL_W-1:0]  velocity_out;
	logic signed [TURN_W-1:0] turn_out;
	logic signed [GAIN_W-1:0] kp_out;
	logic signed [GAIN_W-1:0] ki_out;
	logic signed [GAIN_W-1:0] kd_out;
	logic                     gains_updated;
	logic                     frame_error;

	modport source (output valid, output tuning_mode, output velocity_out,
		output turn_out, output kp_out, output ki_out, output kd_out,
		output gains_updated, output frame_error, input ready);
	modport sink (input valid, input tuning_mode, input velocity_out,
		input turn_out, input kp_out, input ki_out, input kd_out,
		input gains_updated, input frame_error, output ready);
endinterface

FILE: src/rcfp_front.sv
module rcfp_front
	import rcfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rcfp_rx_if.sink   rx,
	input  logic      q_full,
	output logic      push,
	output cmd_t      push_cmd
);

	logic mode_q;
	logic mode_next;

	assign rx.ready  = !q_full;
	assign push      = rx.valid && rx.ready;
	// '9' flips the mode first; the byte is then handled by the new mode
	assign mode_next = mode_q ^ (rx.rx_byte == CH_TOGGLE);

	// Classify the byte
	always_comb begin
		push_cmd.tuning  = mode_next;
		push_cmd.rx_byte = rx.rx_byte;
		push_cmd.op      = OP_NONE;
		if (!mode_next) begin
			case (rx.rx_byte)
				CH_REV:    push_cmd.op = OP_REV;
				CH_LEFT:   push_cmd.op = OP_LEFT;
				CH_STOP:   push_cmd.op = OP_STOP;
				CH_RIGHT:  push_cmd.op = OP_RIGHT;
				CH_FWD:    push_cmd.op = OP_FWD;
				CH_FASTER: push_cmd.op = OP_FASTER;
				CH_SLOWER: push_cmd.op = OP_SLOWER;
				default:   push_cmd.op = OP_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (push) begin
			mode_q <= mode_next;
		end
	end

endmodule

FILE: src/rcfp_queue.sv
module rcfp_queue
	import rcfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic not_empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	// Pointer wrap
	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/rcfp_back.sv
module rcfp_back
	import rcfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_not_empty,
	input  cmd_t       q_cmd,
	output logic       pop,
	rcfp_res_if.source res
);

	logic                     valid_q;
	logic                     mode_out_q;
	logic                     updated_q;
	logic                     error_q;
	logic signed [VEL_W-1:0]  vel_q;
	logic signed [TURN_W-1:0] turn_q;
	logic signed [GAIN_W-1:0] gain_kp_q;
	logic signed [GAIN_W-1:0] gain_ki_q;
	logic signed [GAIN_W-1:0] gain_kd_q;
	logic                     frame_active_q;
	logic [IDX_W-1:0]         byte_idx_q;
	logic signed [GAIN_W-1:0] pend_kp_q;
	logic signed [GAIN_W-1:0] pend_ki_q;
	logic signed [GAIN_W-1:0] pend_kd_q;

	logic signed [GAIN_W-1:0] digit;
	logic signed [GAIN_W-1:0] acc_in;
	logic signed [GAIN_W-1:0] acc_out;
	logic [VEL_W:0]           vel_up;
	logic [VEL_W:0]           vel_dn;

	// State only moves on a pop, so the state registers are the result payload
	assign pop               = q_not_empty && (!valid_q || res.ready);
	assign res.valid         = valid_q;
	assign res.tuning_mode   = mode_out_q;
	assign res.velocity_out  = vel_q;
	assign res.turn_out      = turn_q;
	assign res.kp_out        = gain_kp_q;
	assign res.ki_out        = gain_ki_q;
	assign res.kd_out        = gain_kd_q;
	assign res.gains_updated = updated_q;
	assign res.frame_error   = error_q;

	function automatic logic [VEL_W-1:0] sat16(input logic [VEL_W:0] s);
		if (s[VEL_W] != s[VEL_W-1]) begin
			sat16 = s[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
		end else begin
			sat16 = s[VEL_W-1:0];
		end
	endfunction

	// Velocity steps, one bit of headroom for the saturate check
	assign vel_up = {vel_q[VEL_W-1], vel_q} + {{(VEL_W+1-STEP_W){1'b0}}, cfg.speed_step};
	assign vel_dn = {vel_q[VEL_W-1], vel_q} - {{(VEL_W+1-STEP_W){1'b0}}, cfg.speed_step};

	// Digit accumulate: pending * 10 + (byte - 48), digit not checked
	assign digit = $signed({{(GAIN_W-BYTE_W){1'b0}}, q_cmd.rx_byte})
		- $signed({{(GAIN_W-BYTE_W){1'b0}}, DIGIT_BASE});

	always_comb begin
		if (byte_idx_q inside {[KP_FIRST:KP_LAST]}) begin
			acc_in = pend_kp_q;
		end else if (byte_idx_q inside {[KI_FIRST:KI_LAST]}) begin
			acc_in = pend_ki_q;
		end else begin
			acc_in = pend_kd_q;
		end
		acc_out = (acc_in <<< 3) + (acc_in <<< 1) + digit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= 1'b0;
			mode_out_q     <= 1'b0;
			updated_q      <= 1'b0;
			error_q        <= 1'b0;
			vel_q          <= '0;
			turn_q         <= '0;
			gain_kp_q      <= '0;
			gain_ki_q      <= '0;
			gain_kd_q      <= '0;
			frame_active_q <= 1'b0;
			byte_idx_q     <= '0;
			pend_kp_q      <= '0;
			pend_ki_q      <= '0;
			pend_kd_q      <= '0;
		end else if (pop) begin
			valid_q    <= 1'b1;
			mode_out_q <= q_cmd.tuning;
			updated_q  <= 1'b0;
			error_q    <= 1'b0;
			if (!q_cmd.tuning) begin
				// Drive commands
				case (q_cmd.op)
					OP_REV: begin
						vel_q  <= -$signed({{(VEL_W-SPEED_W){1'b0}}, cfg.drive_speed});
						turn_q <= '0;
					end
					OP_LEFT: begin
						vel_q  <= '0;
						turn_q <= -$signed({{(TURN_W-RATE_W){1'b0}}, cfg.turn_rate});
					end
					OP_STOP: begin
						vel_q  <= '0;
						turn_q <= '0;
					end
					OP_RIGHT: begin
						vel_q  <= '0;
						turn_q <= $signed({{(TURN_W-RATE_W){1'b0}}, cfg.turn_rate});
					end
					OP_FWD: begin
						vel_q  <= $signed({{(VEL_W-SPEED_W){1'b0}}, cfg.drive_speed});
						turn_q <= '0;
					end
					OP_FASTER: begin
						vel_q  <= $signed(sat16(vel_up));
						turn_q <= '0;
					end
					OP_SLOWER: begin
						vel_q  <= $signed(sat16(vel_dn));
						turn_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (!frame_active_q) begin
				// Waiting for header
				if (q_cmd.rx_byte == CH_HEADER) begin
					frame_active_q <= 1'b1;
					byte_idx_q     <= KP_FIRST;
					pend_kp_q      <= '0;
					pend_ki_q      <= '0;
					pend_kd_q      <= '0;
				end
			end else if (byte_idx_q >= LAST_INDEX) begin
				// Trailer slot closes the frame; any other byte there flags an error
				if (q_cmd.rx_byte == CH_TRAILER) begin
					gain_kp_q <= -pend_kp_q;
					gain_ki_q <= -pend_ki_q;
					gain_kd_q <= -pend_kd_q;
					updated_q <= 1'b1;
				end else begin
					error_q <= 1'b1;
				end
				frame_active_q <= 1'b0;
				byte_idx_q     <= '0;
			end else begin
				// Digit bytes
				if (byte_idx_q inside {[KP_FIRST:KP_LAST]}) begin
					pend_kp_q <= acc_out;
				end else if (byte_idx_q inside {[KI_FIRST:KI_LAST]}) begin
					pend_ki_q <= acc_out;
				end else if (byte_idx_q inside {[KD_FIRST:KD_LAST]}) begin
					pend_kd_q <= acc_out;
				end
				byte_idx_q <= byte_idx_q + 1'b1;
			end
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

FILE: src/remote_command_frame_parser.sv
// Remote command frame parser: one received byte in, one result out. A byte is
// accepted every clock cycle when the result side keeps up; the accepting edge
// writes the command queue, and its later pop updates the back end's state
// registers, which are the result. The front end tracks the drive/tuning mode
// and classifies each byte, a two-entry queue decouples it from the back end,
// and the back end updates velocity, turn and the gain frame state, holding its
// result until taken. Drive settings are written over the APB port at byte
// addresses 0, 4 and 8; the user must write them only while the block is idle,
// which the block itself does not enforce.
module remote_command_frame_parser
	import rcfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	rcfp_rx_if.sink           rx,
	rcfp_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	cmd_t q_push_cmd;
	logic q_pop;
	cmd_t q_pop_cmd;
	logic q_not_empty;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_speed <= DRIVE_SPEED_RST;
			cfg_q.turn_rate   <= TURN_RATE_RST;
			cfg_q.speed_step  <= SPEED_STEP_RST;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:2])
				REG_DRIVE_SPEED: cfg_q.drive_speed <= pwdata[SPEED_W-1:0];
				REG_TURN_RATE:   cfg_q.turn_rate   <= pwdata[RATE_W-1:0];
				REG_SPEED_STEP:  cfg_q.speed_step  <= pwdata[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_DRIVE_SPEED: prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_q.drive_speed};
			REG_TURN_RATE:   prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_q.turn_rate};
			REG_SPEED_STEP:  prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_q.speed_step};
			default:         prdata = '0;
		endcase
	end

	rcfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.q_full   (q_full),
		.push     (q_push),
		.push_cmd (q_push_cmd)
	);

	rcfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_cmd   (q_pop_cmd),
		.not_empty (q_not_empty)
	);

	rcfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_cmd       (q_pop_cmd),
		.pop         (q_pop),
		.res         (res)
	);

endmodule

FILE: test/frame_parser_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the APB port of the parser. It tracks mode, frame
// progress, velocity, turn and gains for every byte taken in, and compares
// each status item that leaves the block with the oldest prediction.
module frame_parser_checker
	import rcfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	rcfp_rx_if                rx,
	rcfp_res_if               res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                pending_results,
	output int                mismatches
);

	typedef struct packed {
		logic                     tuning_mode;
		logic signed [VEL_W-1:0]  velocity;
		logic signed [TURN_W-1:0] turn;
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic                     gains_updated;
		logic                     frame_error;
	} parser_status_t;

	// predicted status items, oldest first
	parser_status_t status_q[$];

	// drive settings as last written
	logic [SPEED_W-1:0] drv_speed;
	logic [RATE_W-1:0]  drv_rate;
	logic [STEP_W-1:0]  drv_step;

	// parser state
	logic             tune_mode;
	logic             in_frame;
	logic [IDX_W-1:0] frame_pos;
	int               acc_kp, acc_ki, acc_kd;
	int               vel, turn;
	int               gain_kp, gain_ki, gain_kd;

	function automatic int clamp_velocity(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Advances the parser by one byte and returns the status it should show
	function automatic parser_status_t advance_parser(input logic [BYTE_W-1:0] b);
		parser_status_t s;
		int digit;
		s = '0;
		digit = int'(b) - int'(DIGIT_BASE);
		if (b == CH_TOGGLE)
			tune_mode = ~tune_mode;
		if (tune_mode) begin
			if (!in_frame) begin
				// waiting for a header, everything else is dropped
				if (b == CH_HEADER) begin
					in_frame = 1'b1;
					frame_pos = KP_FIRST;
					acc_kp = 0;
					acc_ki = 0;
					acc_kd = 0;
				end
			end else if (frame_pos >= LAST_INDEX) begin
				// trailer slot: commit negated gains or flag the frame
				if (b == CH_TRAILER) begin
					gain_kp = -acc_kp;
					gain_ki = -acc_ki;
					gain_kd = -acc_kd;
					s.gains_updated = 1'b1;
				end else begin
					s.frame_error = 1'b1;
				end
				in_frame = 1'b0;
				frame_pos = '0;
			end else begin
				// digits are not range checked
				if (frame_pos >= KP_FIRST && frame_pos <= KP_LAST)
					acc_kp = acc_kp * 10 + digit;
				else if (frame_pos >= KI_FIRST && frame_pos <= KI_LAST)
					acc_ki = acc_ki * 10 + digit;
				else if (frame_pos >= KD_FIRST && frame_pos <= KD_LAST)
					acc_kd = acc_kd * 10 + digit;
				frame_pos = frame_pos + 1'b1;
			end
		end else begin
			case (b)
				CH_REV: begin
					vel = -int'(drv_speed);
					turn = 0;
				end
				CH_LEFT: begin
					vel = 0;
					turn = -int'(drv_rate);
				end
				CH_STOP: begin
					vel = 0;
					turn = 0;
				end
				CH_RIGHT: begin
					vel = 0;
					turn = int'(drv_rate);
				end
				CH_FWD: begin
					vel = int'(drv_speed);
					turn = 0;
				end
				CH_FASTER: begin
					vel = clamp_velocity(vel + int'(drv_step));
					turn = 0;
				end
				CH_SLOWER: begin
					vel = clamp_velocity(vel - int'(drv_step));
					turn = 0;
				end
				default: ;
			endcase
		end
		s.tuning_mode = tune_mode;
		s.velocity = VEL_W'(vel);
		s.turn = TURN_W'(turn);
		s.kp = GAIN_W'(gain_kp);
		s.ki = GAIN_W'(gain_ki);
		s.kd = GAIN_W'(gain_kd);
		return s;
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare results first, then predict, then track register writes
	always @(posedge clk or negedge arst_n) begin : monitor
		parser_status_t want;
		if (!arst_n) begin
			status_q.delete();
			drv_speed = DRIVE_SPEED_RST;
			drv_rate = TURN_RATE_RST;
			drv_step = SPEED_STEP_RST;
			tune_mode = 1'b0;
			in_frame = 1'b0;
			frame_pos = '0;
			acc_kp = 0;
			acc_ki = 0;
			acc_kd = 0;
			vel = 0;
			turn = 0;
			gain_kp = 0;
			gain_ki = 0;
			gain_kd = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (status_q.size() == 0) begin
					$error("status item with no byte pending");
					mismatches++;
				end else begin
					want = status_q.pop_front();
					check_field("tuning_mode", want.tuning_mode, res.tuning_mode);
					check_field("velocity_out", want.velocity, res.velocity_out);
					check_field("turn_out", want.turn, res.turn_out);
					check_field("kp_out", want.kp, res.kp_out);
					check_field("ki_out", want.ki, res.ki_out);
					check_field("kd_out", want.kd, res.kd_out);
					check_field("gains_updated", want.gains_updated, res.gains_updated);
					check_field("frame_error", want.frame_error, res.frame_error);
				end
			end
			if (rx.valid && rx.ready)
				status_q.push_back(advance_parser(rx.rx_byte));
			if (psel && penable && pwrite && pready) begin
				// writes to addresses past the last register change nothing
				case (int'(paddr >> 2))
					int'(REG_DRIVE_SPEED): drv_speed = pwdata[SPEED_W-1:0];
					int'(REG_TURN_RATE):   drv_rate = pwdata[RATE_W-1:0];
					int'(REG_SPEED_STEP):  drv_step = pwdata[STEP_W-1:0];
					default: ;
				endcase
			end
		end
		pending_results = status_q.size();
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rcfp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 64;
	localparam int RANDOM_ITEMS = 170;
	localparam int CLIMB_STEPS = 1070;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int pending_results;
	int mismatches;
	int cycles = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int items_sent = 0;
	logic in_tuning = 1'b0;

	rcfp_rx_if  rx();
	rcfp_res_if res();

	remote_command_frame_parser u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	frame_parser_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx),
		.res             (res),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pending_results (pending_results),
		.mismatches      (mismatches)
	);

	always #1 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stalls plus a long hold-off whenever one is requested
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Offers one byte and returns at the falling edge after it is taken;
	// valid stays high so back-to-back items follow without a gap
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx.valid <= 1'b0;
			@(negedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (b == CH_TOGGLE)
			in_tuning = ~in_tuning;
	endtask

	// Stop offering and wait until every status item is back
	task automatic drain();
		rx.valid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] reg_addr(input int idx);
		return ADDR_W'(4 * idx);
	endfunction

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Upper bits of each word are don't-care for the narrow registers
	task automatic set_drive(input logic [DATA_W-1:0] speed, input logic [DATA_W-1:0] rate,
		input logic [DATA_W-1:0] step);
		write_reg(reg_addr(REG_DRIVE_SPEED), speed);
		write_reg(reg_addr(REG_TURN_RATE), rate);
		write_reg(reg_addr(REG_SPEED_STEP), step);
	endtask

	function automatic logic [BYTE_W-1:0] frame_digit();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return DIGIT_BASE + BYTE_W'($urandom_range(9));
		if (pick < 85)
			return BYTE_W'($urandom_range(255));
		return $urandom_range(1) ? 8'hFF : 8'h00;
	endfunction

	task automatic send_frame();
		if (!in_tuning)
			send_byte(CH_TOGGLE);
		send_byte(CH_HEADER);
		for (int pos = 1; pos < FRAME_LENGTH - 1; pos++) begin
			if ($urandom_range(99) < 4) begin
				// detour through drive mode; the toggle back lands as a frame byte
				send_byte(CH_TOGGLE);
				send_byte(CH_REV + BYTE_W'($urandom_range(6)));
				send_byte(CH_TOGGLE);
			end else begin
				send_byte(frame_digit());
			end
		end
		send_byte($urandom_range(99) < 85 ? CH_TRAILER : BYTE_W'($urandom_range(255)));
	endtask

	// Mostly gain frames and drive commands, with step bursts, toggles and noise
	task automatic random_traffic(input int count);
		int stop_at;
		int pick;
		logic [BYTE_W-1:0] step_cmd;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_frame();
			end else if (pick < 70) begin
				if (in_tuning)
					send_byte(CH_TOGGLE);
				send_byte(CH_REV + BYTE_W'($urandom_range(6)));
			end else if (pick < 80) begin
				if (in_tuning)
					send_byte(CH_TOGGLE);
				step_cmd = $urandom_range(1) ? CH_FASTER : CH_SLOWER;
				repeat ($urandom_range(40, 10)) send_byte(step_cmd);
			end else if (pick < 88) begin
				send_byte(CH_TOGGLE);
			end else begin
				send_byte(BYTE_W'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every drive command at reset settings, then one frame with extreme digits
		send_byte(CH_FWD);
		send_byte(CH_FASTER);
		send_byte(CH_SLOWER);
		send_byte(CH_REV);
		send_byte(CH_LEFT);
		send_byte(CH_RIGHT);
		send_byte(CH_STOP);
		send_byte(CH_TOGGLE);
		send_byte(CH_HEADER);
		repeat (5) send_byte(8'hFF);
		repeat (5) send_byte(8'h00);
		for (int k = 1; k <= 5; k++)
			send_byte(DIGIT_BASE + BYTE_W'(k));
		send_byte(CH_TRAILER);

		// largest settings; long step run into the upper velocity limit
		drain();
		set_drive('1, '1, '1);
		write_reg(reg_addr(int'(REG_SPEED_STEP) + 1), $urandom());
		if (in_tuning)
			send_byte(CH_TOGGLE);
		hold_requests++;
		send_byte(CH_FWD);
		repeat (CLIMB_STEPS) send_byte(CH_FASTER);

		// random phases with different settings and handshake pressure
		drain();
		set_drive('0, '0, '0);
		hold_requests++;
		random_traffic(RANDOM_ITEMS);

		drain();
		set_drive($urandom(), $urandom(), $urandom());
		src_idle_pct = 75;
		hold_requests++;
		random_traffic(RANDOM_ITEMS);

		drain();
		set_drive('1, '1, '1);
		src_idle_pct = 0;
		sink_idle_pct = 75;
		hold_requests++;
		random_traffic(RANDOM_ITEMS);

		drain();
		set_drive($urandom(), $urandom(), $urandom());
		src_idle_pct = 11;
		sink_idle_pct = 11;
		hold_requests++;
		random_traffic(RANDOM_ITEMS);

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
